FILE: sv/cflb_pkg.sv
// Package: shared widths, codes, reset values and structs of the command framer / LED unit.
`default_nettype none
package cflb_pkg;

   localparam int KIND_W     = 4;
   localparam int CHAR_W     = 8;
   localparam int RIDX_W     = 5;
   localparam int LEN_W      = 6;
   localparam int DELAY_W    = 16;
   localparam int BLINK_W    = 6;
   localparam int ALARM_W    = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [KIND_W-1:0] {
      KIND_CHAR          = 4'd0,
      KIND_VALID_MOVE    = 4'd1,
      KIND_VALID_OFF     = 4'd2,
      KIND_HEARTBEAT     = 4'd3,
      KIND_PENDING_START = 4'd4,
      KIND_PENDING_BLINK = 4'd5,
      KIND_ERROR_START   = 4'd6,
      KIND_ERROR_BLINK   = 4'd7,
      KIND_OVERFLOW      = 4'd8,
      KIND_RELEASE       = 4'd9,
      KIND_READ          = 4'd10
   } kind_type;

   typedef enum logic [ALARM_W-1:0] {
      ALARM_VALID_OFF     = 2'd0,
      ALARM_PENDING_BLINK = 2'd1,
      ALARM_ERROR_BLINK   = 2'd2
   } alarm_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_DELIM   = 3'd0,
      CSR_END_DELIM     = 3'd1,
      CSR_VALID_DELAY   = 3'd2,
      CSR_PENDING_DELAY = 3'd3,
      CSR_ERROR_DELAY   = 3'd4,
      CSR_PENDING_BLINKS = 3'd5,
      CSR_ERROR_BLINKS  = 3'd6
   } csr_index_type;

   localparam logic [CHAR_W-1:0]  RST_START_DELIM    = 8'h23;
   localparam logic [CHAR_W-1:0]  RST_END_DELIM      = 8'h21;
   localparam logic [DELAY_W-1:0] RST_VALID_DELAY    = 16'h03E8;
   localparam logic [DELAY_W-1:0] RST_PENDING_DELAY  = 16'h01F4;
   localparam logic [DELAY_W-1:0] RST_ERROR_DELAY    = 16'h00FA;
   localparam logic [BLINK_W-1:0] RST_PENDING_BLINKS = 6'd6;
   localparam logic [BLINK_W-1:0] RST_ERROR_BLINKS   = 6'd12;

   typedef struct packed {
      logic [CHAR_W-1:0]  start_delim;
      logic [CHAR_W-1:0]  end_delim;
      logic [DELAY_W-1:0] valid_delay;
      logic [DELAY_W-1:0] pending_delay;
      logic [DELAY_W-1:0] error_delay;
      logic [BLINK_W-1:0] pending_blinks;
      logic [BLINK_W-1:0] error_blinks;
   } cfg_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CHAR_W-1:0] char_value;
      logic [RIDX_W-1:0] read_index;
   } item_type;

   typedef struct packed {
      logic              new_command;
      logic [LEN_W-1:0]  command_length;
      logic [CHAR_W-1:0] read_char;
   } frame_result_type;

   typedef struct packed {
      logic               status_led;
      logic               heartbeat_led;
      logic               overflow_led;
      logic               alarm_request;
      logic [ALARM_W-1:0] alarm_event;
      logic [DELAY_W-1:0] alarm_delay_ms;
   } led_result_type;

endpackage
`default_nettype wire

FILE: sv/cflb_if.sv
// Interfaces: request and response channels with valid/ready handshake.
`default_nettype none
interface cflb_req_if;
   import cflb_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [CHAR_W-1:0] char_value;
   logic [RIDX_W-1:0] read_index;

   modport source (output valid, output kind, output char_value, output read_index,
                   input ready);
   modport sink   (input valid, input kind, input char_value, input read_index,
                   output ready);
endinterface

interface cflb_rsp_if;
   import cflb_pkg::*;

   logic               valid;
   logic               ready;
   logic               new_command;
   logic [LEN_W-1:0]   command_length;
   logic [CHAR_W-1:0]  read_char;
   logic               status_led;
   logic               heartbeat_led;
   logic               overflow_led;
   logic               alarm_request;
   logic [ALARM_W-1:0] alarm_event;
   logic [DELAY_W-1:0] alarm_delay_ms;

   modport source (output valid, output new_command, output command_length,
                   output read_char, output status_led, output heartbeat_led,
                   output overflow_led, output alarm_request, output alarm_event,
                   output alarm_delay_ms, input ready);
   modport sink   (input valid, input new_command, input command_length,
                   input read_char, input status_led, input heartbeat_led,
                   input overflow_led, input alarm_request, input alarm_event,
                   input alarm_delay_ms, output ready);
endinterface
`default_nettype wire

FILE: sv/command_framer_led_blinker_unit.sv
// Top level: input register, framer and LED sequencer, response handshake.
// Throughput: one beat per cycle unless rsp stalls; a req beat passes the input
// register, then the result registers (including the registered read port of the
// command store); these form a two-deep pipe.
// Reset: synchronous, active high; clears control state, LED levels and the
// fill index, arms the framer and reloads the registers; the store is not cleared.
`default_nettype none
module command_framer_led_blinker_unit #(
   parameter int BUFFER_DEPTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   cflb_req_if.sink                          req_bus,
   cflb_rsp_if.source                        rsp_bus,
   input  logic                              csr_wr_en,
   input  logic [cflb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cflb_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import cflb_pkg::*;

   logic             in_valid_ff, in_valid_in;
   item_type         item_ff;
   logic             out_valid_ff, out_valid_in;
   logic             step_en;
   logic             req_accept;
   cfg_type          cfg;
   frame_result_type frame_res;
   led_result_type   led_res;

   assign step_en      = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || step_en;
   assign req_accept   = req_bus.valid && req_bus.ready;
   assign in_valid_in  = req_accept || (in_valid_ff && !step_en);
   assign out_valid_in = step_en || (out_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff.kind       <= req_bus.kind;
         item_ff.char_value <= req_bus.char_value;
         item_ff.read_index <= req_bus.read_index;
      end
   end

   cflb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cflb_framer #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_framer (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (frame_res)
   );

   cflb_leds u_leds (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (led_res)
   );

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.new_command    = frame_res.new_command;
   assign rsp_bus.command_length = frame_res.command_length;
   assign rsp_bus.read_char      = frame_res.read_char;
   assign rsp_bus.status_led     = led_res.status_led;
   assign rsp_bus.heartbeat_led  = led_res.heartbeat_led;
   assign rsp_bus.overflow_led   = led_res.overflow_led;
   assign rsp_bus.alarm_request  = led_res.alarm_request;
   assign rsp_bus.alarm_event    = led_res.alarm_event;
   assign rsp_bus.alarm_delay_ms = led_res.alarm_delay_ms;

   a_full_pipe_blocks: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_bus.ready && in_valid_ff) |-> !req_bus.ready)
      else $error("req beat taken while both stages are held");

endmodule
`default_nettype wire

FILE: sv/cflb_csr.sv
// Configuration register file: delimiters, alarm delays and blink counts.
`default_nettype none
module cflb_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [cflb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cflb_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output cflb_pkg::cfg_type                   cfg
);
   import cflb_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_START_DELIM:    cfg_in.start_delim    = csr_wdata[CHAR_W-1:0];
            CSR_END_DELIM:      cfg_in.end_delim      = csr_wdata[CHAR_W-1:0];
            CSR_VALID_DELAY:    cfg_in.valid_delay    = csr_wdata[DELAY_W-1:0];
            CSR_PENDING_DELAY:  cfg_in.pending_delay  = csr_wdata[DELAY_W-1:0];
            CSR_ERROR_DELAY:    cfg_in.error_delay    = csr_wdata[DELAY_W-1:0];
            CSR_PENDING_BLINKS: cfg_in.pending_blinks = csr_wdata[BLINK_W-1:0];
            CSR_ERROR_BLINKS:   cfg_in.error_blinks   = csr_wdata[BLINK_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_delim    <= RST_START_DELIM;
         cfg_ff.end_delim      <= RST_END_DELIM;
         cfg_ff.valid_delay    <= RST_VALID_DELAY;
         cfg_ff.pending_delay  <= RST_PENDING_DELAY;
         cfg_ff.error_delay    <= RST_ERROR_DELAY;
         cfg_ff.pending_blinks <= RST_PENDING_BLINKS;
         cfg_ff.error_blinks   <= RST_ERROR_BLINKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

FILE: sv/cflb_framer.sv
// Command framer: fill index, armed flag, command store and registered read.
`default_nettype none
module cflb_framer #(
   parameter int BUFFER_DEPTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step_en,
   input  cflb_pkg::item_type             item,
   input  cflb_pkg::cfg_type              cfg,
   output cflb_pkg::frame_result_type     result
);
   import cflb_pkg::*;

   localparam int AW  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int FW  = $clog2(BUFFER_DEPTH + 1);
   localparam int LW  = (FW > LEN_W) ? FW : LEN_W;
   localparam int IW  = (FW > RIDX_W) ? FW : RIDX_W;
   localparam int RAW = (AW > RIDX_W) ? AW : RIDX_W;

   logic [FW-1:0]     fill_ff, fill_in;
   logic              armed_ff, armed_in;
   logic              new_command_ff, new_command_in;
   logic              rd_hit_ff, rd_hit_in;
   logic [CHAR_W-1:0] rd_data_ff;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [AW-1:0]     rd_addr;
   logic [RAW-1:0]    rd_ext;
   logic [LW-1:0]     len_ext;
   logic              store_full;

   logic [CHAR_W-1:0] store_mem [BUFFER_DEPTH];

   assign store_full = (fill_ff >= FW'(BUFFER_DEPTH));
   assign wr_addr    = fill_ff[AW-1:0];
   assign rd_ext     = RAW'(item.read_index);
   assign rd_addr    = rd_ext[AW-1:0];

   always_comb begin
      fill_in        = fill_ff;
      armed_in       = armed_ff;
      new_command_in = 1'b0;
      rd_hit_in      = 1'b0;
      wr_en          = 1'b0;
      case (kind_type'(item.kind))
         KIND_CHAR: begin
            if (armed_ff) begin
               // start delimiter wins over end delimiter when both match
               if (item.char_value == cfg.start_delim) begin
                  fill_in = '0;
               end else if (!store_full) begin
                  wr_en   = 1'b1;
                  fill_in = fill_ff + FW'(1);
                  if (item.char_value == cfg.end_delim) begin
                     new_command_in = 1'b1;
                     armed_in       = 1'b0;
                  end
               end else begin
                  fill_in = '0;
               end
            end
         end
         KIND_RELEASE: begin
            armed_in = 1'b1;
            fill_in  = '0;
         end
         KIND_READ: begin
            rd_hit_in = (IW'(item.read_index) < IW'(fill_ff));
         end
         default: begin
            fill_in = fill_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff        <= '0;
         armed_ff       <= 1'b1;
         new_command_ff <= 1'b0;
         rd_hit_ff      <= 1'b0;
      end else if (step_en) begin
         fill_ff        <= fill_in;
         armed_ff       <= armed_in;
         new_command_ff <= new_command_in;
         rd_hit_ff      <= rd_hit_in;
      end
   end

   // read sees only writes of earlier beats: a read beat never writes
   always_ff @(posedge clock) begin
      if (step_en && wr_en) begin
         store_mem[wr_addr] <= item.char_value;
      end
      if (step_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign len_ext               = LW'(fill_ff);
   assign result.new_command    = new_command_ff;
   assign result.command_length = len_ext[LEN_W-1:0];
   assign result.read_char      = rd_hit_ff ? rd_data_ff : '0;

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(BUFFER_DEPTH))
      else $error("fill index beyond store depth");

   a_new_cmd_disarms: assert property (@(posedge clock) disable iff (reset)
      new_command_ff |-> !armed_ff)
      else $error("framer still armed after end delimiter");

endmodule
`default_nettype wire

FILE: sv/cflb_leds.sv
// LED sequencer: status, heartbeat and overflow levels, blink counter, alarm requests.
`default_nettype none
module cflb_leds (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step_en,
   input  cflb_pkg::item_type          item,
   input  cflb_pkg::cfg_type           cfg,
   output cflb_pkg::led_result_type    result
);
   import cflb_pkg::*;

   logic [BLINK_W-1:0] count_ff, count_in;
   logic               status_ff, status_in;
   logic               heartbeat_ff, heartbeat_in;
   logic               overflow_ff, overflow_in;
   logic               alarm_request_ff, alarm_request_in;
   alarm_type          alarm_event_ff, alarm_event_in;
   logic [DELAY_W-1:0] alarm_delay_ff, alarm_delay_in;

   logic               is_blink;
   logic [BLINK_W-1:0] blink_limit;
   logic [DELAY_W-1:0] blink_delay;
   alarm_type          blink_event;

   // pending and error sequences share one counter
   always_comb begin
      is_blink    = 1'b0;
      blink_limit = cfg.pending_blinks;
      blink_delay = cfg.pending_delay;
      blink_event = ALARM_PENDING_BLINK;
      case (kind_type'(item.kind))
         KIND_PENDING_BLINK: begin
            is_blink = 1'b1;
         end
         KIND_ERROR_BLINK: begin
            is_blink    = 1'b1;
            blink_limit = cfg.error_blinks;
            blink_delay = cfg.error_delay;
            blink_event = ALARM_ERROR_BLINK;
         end
         default: begin
            is_blink = 1'b0;
         end
      endcase
   end

   always_comb begin
      count_in         = count_ff;
      status_in        = status_ff;
      heartbeat_in     = heartbeat_ff;
      overflow_in      = overflow_ff;
      alarm_request_in = 1'b0;
      alarm_event_in   = ALARM_VALID_OFF;
      alarm_delay_in   = '0;
      case (kind_type'(item.kind))
         KIND_VALID_MOVE: begin
            status_in        = 1'b1;
            alarm_request_in = 1'b1;
            alarm_delay_in   = cfg.valid_delay;
         end
         KIND_VALID_OFF: begin
            status_in = 1'b0;
         end
         KIND_HEARTBEAT: begin
            heartbeat_in = ~heartbeat_ff;
         end
         KIND_PENDING_START: begin
            count_in         = BLINK_W'(1);
            status_in        = 1'b1;
            alarm_request_in = 1'b1;
            alarm_event_in   = ALARM_PENDING_BLINK;
            alarm_delay_in   = cfg.pending_delay;
         end
         KIND_ERROR_START: begin
            count_in         = BLINK_W'(1);
            status_in        = 1'b1;
            alarm_request_in = 1'b1;
            alarm_event_in   = ALARM_ERROR_BLINK;
            alarm_delay_in   = cfg.error_delay;
         end
         KIND_OVERFLOW: begin
            overflow_in = 1'b1;
         end
         default: begin
            if (is_blink) begin
               if (count_ff == blink_limit) begin
                  count_in  = '0;
                  status_in = 1'b0;
               end else begin
                  status_in        = ~status_ff;
                  count_in         = count_ff + BLINK_W'(1);
                  alarm_request_in = 1'b1;
                  alarm_event_in   = blink_event;
                  alarm_delay_in   = blink_delay;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff         <= '0;
         status_ff        <= 1'b0;
         heartbeat_ff     <= 1'b0;
         overflow_ff      <= 1'b0;
         alarm_request_ff <= 1'b0;
         alarm_event_ff   <= ALARM_VALID_OFF;
         alarm_delay_ff   <= '0;
      end else if (step_en) begin
         count_ff         <= count_in;
         status_ff        <= status_in;
         heartbeat_ff     <= heartbeat_in;
         overflow_ff      <= overflow_in;
         alarm_request_ff <= alarm_request_in;
         alarm_event_ff   <= alarm_event_in;
         alarm_delay_ff   <= alarm_delay_in;
      end
   end

   assign result.status_led     = status_ff;
   assign result.heartbeat_led  = heartbeat_ff;
   assign result.overflow_led   = overflow_ff;
   assign result.alarm_request  = alarm_request_ff;
   assign result.alarm_event    = alarm_event_ff;
   assign result.alarm_delay_ms = alarm_delay_ff;

   a_idle_alarm_zero: assert property (@(posedge clock) disable iff (reset)
      !alarm_request_ff |-> (alarm_delay_ff == '0 && alarm_event_ff == ALARM_VALID_OFF))
      else $error("alarm fields not cleared without request");

   a_overflow_sticky: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |=> overflow_ff)
      else $error("overflow LED dropped");

endmodule
`default_nettype wire
